/* hdl/ghp_pkg.sv */
`timescale 1ns / 1ps

package ghp_pkg;

    // Fixed field widths
    localparam int HANDLE_W = 26;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 9;

    // Build defaults
    localparam int POOL_DEPTH_DEF    = 256;
    localparam int HANDLE_STRIDE_DEF = 1000;
    localparam int GEN_BITS_DEF      = 16;

    localparam logic [CFG_W-1:0] POOL_SIZE_RST = 9'd256;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DISPOSE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

    // Result status
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_STACKFULL = 2'd3;

endpackage

/* hdl/ghp_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, one write port, one read port, registered read.
module ghp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/generational_handle_pool.sv */
`timescale 1ns / 1ps

// Channel    Ports                                          Direction  Handshake
// request    start, kind, handle                            in         start & !busy
// result     done, handle_out, status, occupied, valid_res  out        done, one cycle
// config     cfg_we, cfg_wdata (pool_size)                  in         cfg_we, no wait
//
// One request is in flight at a time. Every request passes DECODE, SPLIT and
// ISSUE; allocate from a fresh slot, dispose and query then end in LOOKUP, and
// allocate that pops the free stack passes POP first (extra stack memory read);
// requests that end early (pool full, index out of range, unused kind) finish
// in ISSUE. busy drops in the done cycle, so a new request can be accepted at
// the edge that ends it. After reset the slot memory is swept to zero, one
// entry per cycle, with busy high. The result side cannot stall.
module generational_handle_pool #(
    parameter int POOL_DEPTH    = ghp_pkg::POOL_DEPTH_DEF,
    parameter int HANDLE_STRIDE = ghp_pkg::HANDLE_STRIDE_DEF,
    parameter int GEN_BITS      = ghp_pkg::GEN_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ghp_pkg::KIND_W-1:0]    kind,
    input  logic [ghp_pkg::HANDLE_W-1:0]  handle,
    output logic                          busy,
    output logic                          done,
    output logic [ghp_pkg::HANDLE_W-1:0]  handle_out,
    output logic [ghp_pkg::STATUS_W-1:0]  status,
    output logic                          occupied,
    output logic                          valid_res,
    input  logic                          cfg_we,
    input  logic [ghp_pkg::CFG_W-1:0]     cfg_wdata
);

    import ghp_pkg::*;

    // Widths derived from the build parameters
    localparam int IDX_W    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W    = $clog2(POOL_DEPTH + 1);
    localparam int SLOT_W   = $clog2(HANDLE_STRIDE);
    localparam int STRIDE_W = $clog2(HANDLE_STRIDE + 1);
    localparam int QUO_W    = HANDLE_W - $clog2(HANDLE_STRIDE) + 1;
    localparam int HP_W     = GEN_BITS + STRIDE_W;
    localparam int RM_W     = QUO_W + STRIDE_W;
    localparam int SLOTM_W  = GEN_BITS + 1;

    // Handle decode: quotient by reciprocal multiply. With a ceiling
    // reciprocal and shift = handle bits + log2(stride) the quotient is exact
    // over the whole handle range, so no correction step is needed.
    localparam int DIV_SHIFT = HANDLE_W + $clog2(HANDLE_STRIDE);
    localparam int PROD_W    = 2 * HANDLE_W + 1;
    localparam logic [HANDLE_W:0] DIV_MULT = (HANDLE_W + 1)'(
        ((64'd1 << DIV_SHIFT) + 64'(HANDLE_STRIDE) - 64'd1) / 64'(HANDLE_STRIDE));

    // Sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;  // reciprocal multiply
    localparam logic [2:0] ST_SPLIT  = 3'd3;  // remainder -> slot, quotient -> gen
    localparam logic [2:0] ST_ISSUE  = 3'd4;  // range check, memory read issue
    localparam logic [2:0] ST_POP    = 3'd5;  // free stack data back
    localparam logic [2:0] ST_LOOKUP = 3'd6;  // slot data back, write back, result

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0] free_count_reg, free_count_next;
    logic [CNT_W-1:0] next_fresh_reg, next_fresh_next;
    logic [CFG_W-1:0] pool_size_reg;
    logic             done_reg, done_next;

    // Request payload and decode pipeline
    logic [KIND_W-1:0]   kind_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [QUO_W-1:0]    dgen_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    // Result registers
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_occ_reg, res_occ_next;
    logic                res_val_reg, res_val_next;

    // Decode datapath
    logic [QUO_W-1:0]    quo_calc;
    logic [HANDLE_W-1:0] rem_calc;
    logic [CNT_W-1:0]    eff_size;
    logic                slot_oor;

    // Slot memory {in_use, generation}
    logic               slot_we;
    logic [IDX_W-1:0]   slot_waddr, slot_raddr;
    logic [SLOTM_W-1:0] slot_wdata, slot_rdata;

    // Free stack memory
    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr, stk_raddr;
    logic [IDX_W-1:0] stk_wdata, stk_rdata;

    ghp_ram #(
        .WIDTH (SLOTM_W),
        .DEPTH (POOL_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    ghp_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign quo_calc = QUO_W'(prod_reg >> DIV_SHIFT);
    assign rem_calc = handle_reg
                    - HANDLE_W'(RM_W'(quo_calc) * RM_W'(HANDLE_STRIDE));

    // Effective size is min(pool_size, POOL_DEPTH); it always fits CNT_W.
    always_comb
    begin
        if (32'(pool_size_reg) < 32'(POOL_DEPTH))
        begin
            eff_size = CNT_W'(pool_size_reg);
        end
        else
        begin
            eff_size = CNT_W'(POOL_DEPTH);
        end
    end

    assign slot_oor = (32'(slot_reg) >= 32'(eff_size));

    // Sequencer. Only one request is in flight and the slot write in LOOKUP
    // lands before the next request reaches its read in ISSUE, so the
    // read-modify-write needs no forwarding path.
    always_comb
    begin
        logic [GEN_BITS-1:0] new_gen;
        logic [IDX_W-1:0]    pop_idx;

        new_gen = slot_rdata[GEN_BITS-1:0] + GEN_BITS'(1);
        pop_idx = stk_rdata;
        if (32'(stk_rdata) >= 32'(POOL_DEPTH))
        begin
            pop_idx = '0;
        end

        state_next      = state_reg;
        clr_next        = clr_reg;
        free_count_next = free_count_reg;
        next_fresh_next = next_fresh_reg;
        done_next       = 1'b0;
        idx_next        = idx_reg;

        res_handle_next = res_handle_reg;
        res_status_next = res_status_reg;
        res_occ_next    = res_occ_reg;
        res_val_next    = res_val_reg;

        slot_we    = 1'b0;
        slot_waddr = idx_reg;
        slot_wdata = slot_rdata;
        slot_raddr = idx_reg;

        stk_we    = 1'b0;
        stk_waddr = IDX_W'(free_count_reg);
        stk_wdata = idx_reg;
        stk_raddr = IDX_W'(free_count_reg - CNT_W'(1));

        case (state_reg)
            ST_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = '0;
                if (clr_reg == IDX_W'(POOL_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IDX_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                state_next = ST_SPLIT;
            end

            ST_SPLIT:
            begin
                state_next = ST_ISSUE;
            end

            ST_ISSUE:
            begin
                // default outcome: finish now with an empty result
                res_handle_next = '0;
                res_status_next = STATUS_OK;
                res_occ_next    = 1'b0;
                res_val_next    = 1'b0;
                case (kind_reg)
                    KIND_ALLOC:
                    begin
                        if (free_count_reg != '0)
                        begin
                            // LIFO pop: stack read at free_count - 1
                            free_count_next = free_count_reg - CNT_W'(1);
                            state_next      = ST_POP;
                        end
                        else if (next_fresh_reg < eff_size)
                        begin
                            idx_next        = IDX_W'(next_fresh_reg);
                            slot_raddr      = IDX_W'(next_fresh_reg);
                            next_fresh_next = next_fresh_reg + CNT_W'(1);
                            state_next      = ST_LOOKUP;
                        end
                        else
                        begin
                            res_status_next = STATUS_FULL;
                            done_next       = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end

                    KIND_DISPOSE, KIND_QUERY:
                    begin
                        if (slot_oor)
                        begin
                            res_status_next = STATUS_RANGE;
                            done_next       = 1'b1;
                            state_next      = ST_IDLE;
                        end
                        else
                        begin
                            idx_next   = IDX_W'(slot_reg);
                            slot_raddr = IDX_W'(slot_reg);
                            state_next = ST_LOOKUP;
                        end
                    end

                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_POP:
            begin
                idx_next   = pop_idx;
                slot_raddr = pop_idx;
                state_next = ST_LOOKUP;
            end

            ST_LOOKUP:
            begin
                res_handle_next = '0;
                res_status_next = STATUS_OK;
                res_occ_next    = 1'b0;
                res_val_next    = 1'b0;
                done_next       = 1'b1;
                state_next      = ST_IDLE;
                case (kind_reg)
                    KIND_ALLOC:
                    begin
                        slot_we         = 1'b1;
                        slot_wdata      = {1'b1, new_gen};
                        res_handle_next = HANDLE_W'(HP_W'(new_gen) * HP_W'(HANDLE_STRIDE)
                                                    + HP_W'(idx_reg));
                    end

                    KIND_DISPOSE:
                    begin
                        slot_we    = 1'b1;
                        slot_wdata = {1'b0, slot_rdata[GEN_BITS-1:0]};
                        if (free_count_reg >= CNT_W'(POOL_DEPTH))
                        begin
                            res_status_next = STATUS_STACKFULL;
                        end
                        else
                        begin
                            stk_we          = 1'b1;
                            free_count_next = free_count_reg + CNT_W'(1);
                        end
                    end

                    KIND_QUERY:
                    begin
                        res_occ_next = slot_rdata[GEN_BITS];
                        res_val_next = slot_rdata[GEN_BITS]
                                     && (33'(slot_rdata[GEN_BITS-1:0]) == 33'(dgen_reg));
                    end

                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            free_count_reg <= '0;
            next_fresh_reg <= '0;
            pool_size_reg  <= POOL_SIZE_RST;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            free_count_reg <= free_count_next;
            next_fresh_reg <= next_fresh_next;
            done_reg       <= done_next;
            if (cfg_we)
            begin
                pool_size_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg   <= kind;
            handle_reg <= handle;
        end
        if (state_reg == ST_DECODE)
        begin
            prod_reg <= PROD_W'(handle_reg) * PROD_W'(DIV_MULT);
        end
        if (state_reg == ST_SPLIT)
        begin
            slot_reg <= SLOT_W'(rem_calc);
            dgen_reg <= quo_calc;
        end
        idx_reg        <= idx_next;
        res_handle_reg <= res_handle_next;
        res_status_reg <= res_status_next;
        res_occ_reg    <= res_occ_next;
        res_val_reg    <= res_val_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign handle_out = res_handle_reg;
    assign status     = res_status_reg;
    assign occupied   = res_occ_reg;
    assign valid_res  = res_val_reg;

endmodule

/* hdl/ghp_checker.sv */
`timescale 1ns / 1ps

module ghp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [ghp_pkg::HANDLE_W-1:0] handle_out,
    input logic [ghp_pkg::STATUS_W-1:0] status,
    input logic                         occupied,
    input logic                         valid_res
);

    import ghp_pkg::*;

    // an accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    // no result in the cycle right after an accept
    a_no_instant_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !done)
        else $error("result strobe directly after accept");

    // result cycle frees the request side
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy during result cycle");

    // failed requests carry no handle
    a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != STATUS_OK) |-> handle_out == '0)
        else $error("nonzero handle on failed request");

    // a valid handle implies the slot is occupied
    a_valid_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done && valid_res |-> occupied)
        else $error("valid_res without occupied");

endmodule

bind generational_handle_pool ghp_checker u_ghp_checker (.*);

/* verif/tb_generational_handle_pool.sv */
`timescale 1ns / 1ps

// Testbench for the generational handle pool.
// Requests go in on the start/busy handshake and are driven on the falling edge.
// Replies are one-cycle done strobes and are sampled on the rising edge.
// A small mirror of the pool predicts every reply when its request is accepted,
// and the reply monitor checks each strobe against the oldest prediction.
module tb_generational_handle_pool;
    import ghp_pkg::*;

    // Kind code that the block does not define: it must answer with all zeros
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int STACK_PTR_W = $clog2(POOL_DEPTH_DEF);
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic [STATUS_W-1:0] status;
        logic                occupied;
        logic                valid_res;
    } pool_reply_t;

    // Mirror of the pool: slot state, free stack and pool_size, plus the queue
    // of replies predicted for requests that are still in flight.
    class handle_pool_mirror;
        bit [CFG_W-1:0]        pool_size;
        bit                    in_use [POOL_DEPTH_DEF];
        bit [GEN_BITS_DEF-1:0] gen_tab [POOL_DEPTH_DEF];
        bit [STACK_PTR_W-1:0]  free_stack [POOL_DEPTH_DEF];
        int unsigned           free_count;
        int unsigned           next_fresh;
        pool_reply_t           pending [$];
        int unsigned           errors;

        function new();
            pool_size = POOL_SIZE_RST;
        endfunction

        // Mark a slot taken, bump its generation (wraps) and build the handle
        function logic [HANDLE_W-1:0] claim(int unsigned idx);
            longint unsigned h;
            in_use[idx] = 1'b1;
            gen_tab[idx] = gen_tab[idx] + 1'b1;
            h = gen_tab[idx];
            h = h * HANDLE_STRIDE_DEF + idx;
            return h[HANDLE_W-1:0];
        endfunction

        function pool_reply_t note_request(logic [KIND_W-1:0] k, logic [HANDLE_W-1:0] h);
            int unsigned hv;
            int unsigned slot;
            int unsigned gen_in;
            int unsigned eff;
            int unsigned idx;
            pool_reply_t r;
            r = '0;
            hv = 32'(h);
            slot = hv % HANDLE_STRIDE_DEF;
            gen_in = hv / HANDLE_STRIDE_DEF;
            eff = (32'(pool_size) < POOL_DEPTH_DEF) ? 32'(pool_size) : POOL_DEPTH_DEF;
            case (k)
                KIND_ALLOC:
                begin
                    // LIFO reuse first, even if the slot is beyond a shrunk pool
                    if (free_count > 0)
                    begin
                        free_count--;
                        idx = 32'(free_stack[free_count]);
                        r.handle_out = claim(idx);
                    end
                    else if (next_fresh < eff)
                    begin
                        r.handle_out = claim(next_fresh);
                        next_fresh++;
                    end
                    else
                        r.status = STATUS_FULL;
                end
                KIND_DISPOSE:
                begin
                    if (slot >= eff)
                        r.status = STATUS_RANGE;
                    else
                    begin
                        in_use[slot] = 1'b0;
                        if (free_count >= POOL_DEPTH_DEF)
                            r.status = STATUS_STACKFULL;
                        else
                        begin
                            free_stack[free_count] = slot[STACK_PTR_W-1:0];
                            free_count++;
                        end
                    end
                end
                KIND_QUERY:
                begin
                    if (slot >= eff)
                        r.status = STATUS_RANGE;
                    else
                    begin
                        r.occupied = in_use[slot];
                        // full decoded generation, so gen > 16 bits never matches
                        r.valid_res = in_use[slot] && (32'(gen_tab[slot]) == gen_in);
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
            return r;
        endfunction

        function void report(string msg);
            if (errors < 10)
                $display("%0t %s", $time, msg);
            errors++;
        endfunction

        function void check_reply(pool_reply_t got);
            pool_reply_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unrequested reply handle_out=%0d status=%0d",
                                 got.handle_out, got.status));
                return;
            end
            want = pending.pop_front();
            if (got.handle_out !== want.handle_out || got.status !== want.status ||
                got.occupied !== want.occupied || got.valid_res !== want.valid_res)
                report($sformatf({"reply mismatch: expected handle_out=%0d status=%0d ",
                                  "occupied=%0b valid_res=%0b, got handle_out=%0d ",
                                  "status=%0d occupied=%0b valid_res=%0b"},
                                 want.handle_out, want.status, want.occupied,
                                 want.valid_res, got.handle_out, got.status,
                                 got.occupied, got.valid_res));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [KIND_W-1:0]   kind = KIND_ALLOC;
    logic [HANDLE_W-1:0] handle = '0;
    logic                busy;
    logic                done;
    logic [HANDLE_W-1:0] handle_out;
    logic [STATUS_W-1:0] status;
    logic                occupied;
    logic                valid_res;
    logic                cfg_we = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    handle_pool_mirror   mirror;
    logic [HANDLE_W-1:0] live_handles [$];   // handles handed out, some stale
    int                  idle_pct = 0;       // chance per cycle that the sender holds off
    int                  idle_plan [4] = '{0, 60, 0, 28};
    int unsigned         cycle_count = 0;

    generational_handle_pool dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .handle     (handle),
        .busy       (busy),
        .done       (done),
        .handle_out (handle_out),
        .status     (status),
        .occupied   (occupied),
        .valid_res  (valid_res),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: the slowest legal run is far below this
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Reply monitor: the strobe lasts one cycle and cannot be held off
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            mirror.check_reply({handle_out, status, occupied, valid_res});
    end

    // Issue one request; entered and left on a falling edge. start is left high
    // so back-to-back requests are taken as soon as busy drops.
    task automatic send_req(input logic [KIND_W-1:0] k, input logic [HANDLE_W-1:0] h,
                            output pool_reply_t want);
        bit accepted;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start  <= 1'b1;
        kind   <= k;
        handle <= h;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(posedge clk);
            accepted = (busy == 1'b0);
        end
        want = mirror.note_request(k, h);
        @(negedge clk);
    endtask

    // Stop sending and wait for every predicted reply; the tail covers the
    // longest request (allocate with a free stack pop) so the block is truly idle after.
    task automatic drain_replies();
        start <= 1'b0;
        do
            @(posedge clk);
        while (mirror.pending.size() != 0 || busy !== 1'b0);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    // pool_size only changes with nothing in flight
    task automatic write_pool_size(input logic [CFG_W-1:0] v);
        drain_replies();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        mirror.pool_size = v;
    endtask

    // Mostly well-formed traffic: allocate, then dispose or query handles that
    // were handed out (some already stale), with a share of raw noise.
    task automatic run_mixed(input int n, input int alloc_pct);
        pool_reply_t         rep;
        int                  r;
        int                  j;
        logic [HANDLE_W-1:0] h;
        logic [KIND_W-1:0]   k;
        repeat (n)
        begin
            r = $urandom_range(99);
            h = HANDLE_W'($urandom);
            k = KIND_ALLOC;
            if (r < alloc_pct)
                k = KIND_ALLOC;
            else if (r < 90 && live_handles.size() > 0)
            begin
                j = $urandom_range(live_handles.size() - 1);
                h = live_handles[j];
                if (r < alloc_pct + (90 - alloc_pct) / 2)
                begin
                    k = KIND_DISPOSE;
                    // keep some around for double dispose and stale queries
                    if ($urandom_range(3) != 0)
                        live_handles.delete(j);
                end
                else
                begin
                    k = KIND_QUERY;
                    if ($urandom_range(4) == 0)
                        h = HANDLE_W'(32'(h) + HANDLE_STRIDE_DEF);   // next generation
                end
            end
            else
            begin
                k = KIND_W'($urandom_range(3));
                if ($urandom_range(1))
                    h = HANDLE_W'($urandom_range(65535) * HANDLE_STRIDE_DEF
                                  + $urandom_range(999));
            end
            send_req(k, h, rep);
            if (k == KIND_ALLOC && rep.status == STATUS_OK)
            begin
                live_handles.push_back(rep.handle_out);
                if (live_handles.size() > 64)
                    void'(live_handles.pop_front());
            end
        end
    endtask

    initial
    begin
        pool_reply_t rep;
        int          sz;
        mirror = new();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // let the post-reset memory sweep begin before the idle check
        repeat (4) @(posedge clk);

        // Directed: generations, double dispose, range bounds, unused kind
        write_pool_size(9'd256);
        send_req(KIND_QUERY, 26'd0, rep);            // never allocated
        send_req(KIND_ALLOC, 26'h3FFFFFF, rep);      // fresh slot 0, gen 1
        send_req(KIND_ALLOC, 26'd0, rep);            // fresh slot 1
        send_req(KIND_QUERY, 26'd1000, rep);         // live and current
        send_req(KIND_QUERY, 26'd2000, rep);         // live, wrong generation
        send_req(KIND_QUERY, 26'd65535999, rep);     // slot 999, out of range
        send_req(KIND_QUERY, 26'd67108001, rep);     // generation beyond 16 bits
        send_req(KIND_DISPOSE, 26'd1001, rep);
        send_req(KIND_DISPOSE, 26'd1001, rep);       // same slot pushed twice
        send_req(KIND_ALLOC, 26'd0, rep);            // pops slot 1
        send_req(KIND_ALLOC, 26'd0, rep);            // pops slot 1 again while in use
        send_req(KIND_DISPOSE, 26'd999, rep);        // out of range
        send_req(KIND_DISPOSE, 26'd256, rep);        // first index past the pool
        send_req(KIND_DISPOSE, 26'd255, rep);        // last slot, never allocated
        send_req(KIND_UNUSED, 26'h3FFFFFF, rep);     // ignored kind, all zero reply
        send_req(KIND_QUERY, 26'd255, rep);

        // Shrunk pool: the stacked slot 255 is still reused
        write_pool_size(9'd2);
        send_req(KIND_ALLOC, 26'd0, rep);
        send_req(KIND_ALLOC, 26'd0, rep);            // no fresh slots left: full
        send_req(KIND_DISPOSE, 26'd2, rep);
        send_req(KIND_QUERY, 26'd1255, rep);

        // Empty pool: everything out of range, allocate fails
        write_pool_size(9'd0);
        send_req(KIND_ALLOC, 26'd0, rep);
        send_req(KIND_QUERY, 26'd0, rep);
        send_req(KIND_DISPOSE, 26'd0, rep);

        // Oversized setting clamps to the built depth
        write_pool_size(9'd511);
        send_req(KIND_ALLOC, 26'd0, rep);
        send_req(KIND_QUERY, 26'd1002, rep);

        // Random phases: pool size and sender idling vary; every phase change
        // waits for all replies, so the sender fully pauses several times.
        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0:       sz = 256;
                1:       sz = 5;
                2:       sz = 1;
                3:       sz = 0;
                4:       sz = 511;
                5:       sz = $urandom_range(256, 1);
                6:       sz = 300;
                7:       sz = $urandom_range(16, 1);
                8:       sz = 256;
                9:       sz = $urandom_range(256, 1);
                10:      sz = 2;
                default: sz = 256;
            endcase
            idle_pct = idle_plan[p % 4];
            write_pool_size(CFG_W'(sz));
            if (p == 8)
            begin
                // Flood disposes until the free stack overflows, then pop some back
                repeat (270)
                    send_req(KIND_DISPOSE,
                             HANDLE_W'($urandom_range(65535) * HANDLE_STRIDE_DEF
                                       + $urandom_range(255)),
                             rep);
                run_mixed(20, 90);
            end
            else
                run_mixed(40, (p == 2 || p == 10) ? 70 : 40);
        end

        drain_replies();
        if (mirror.errors == 0 && mirror.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* generational_handle_pool.f */
hdl/ghp_pkg.sv
hdl/ghp_ram.sv
hdl/generational_handle_pool.sv
hdl/ghp_checker.sv
verif/tb_generational_handle_pool.sv
